[sv/roman_numeral_encoder_unit_assert.svh]
// Assertion macros shared by the Roman numeral encoder modules.
`ifndef ROMAN_NUMERAL_ENCODER_UNIT_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RNE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define RNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rne_pkg.sv]
// Shared types, constants and the microcode program of the Roman numeral encoder.
package rne_pkg;

  localparam int NumW    = 12;
  localparam int SymW    = 7;
  localparam int WeightW = 10;
  localparam int StepW   = 5;
  localparam int ProgLen = 19;

  localparam logic [NumW-1:0] NumberMax = 12'd3999;

  // ASCII codes of the numeral characters.
  localparam logic [SymW-1:0] ChrI = 7'h49;
  localparam logic [SymW-1:0] ChrV = 7'h56;
  localparam logic [SymW-1:0] ChrX = 7'h58;
  localparam logic [SymW-1:0] ChrL = 7'h4C;
  localparam logic [SymW-1:0] ChrC = 7'h43;
  localparam logic [SymW-1:0] ChrD = 7'h44;
  localparam logic [SymW-1:0] ChrM = 7'h4D;

  // Control word codes.
  localparam logic CondTest   = 1'b1;
  localparam logic CondAlways = 1'b0;
  localparam logic SubYes     = 1'b1;
  localparam logic SubNo      = 1'b0;

  // One microcode word: emit sym when the test passes (or always), optionally
  // subtract weight, and jump to target; a failed test falls through,
  // and a failed test on the first word of a pair also skips the pair's second word.
  typedef struct packed {
    logic               cond;
    logic               sub;
    logic [StepW-1:0]   target;
    logic [SymW-1:0]    sym;
    logic [WeightW-1:0] weight;
  } uword_t;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic               load;
    logic               load_err;
    logic               emit;
    logic               sub;
    logic [SymW-1:0]    sym;
    logic [WeightW-1:0] weight;
  } ctrl_t;

  // Datapath to sequencer status.
  typedef struct packed {
    logic in_range;
    logic ge;
    logic eq;
    logic slot_free;
  } stat_t;

  // The program: one or two steps per table entry, largest weight first.
  function automatic uword_t uword(input logic [StepW-1:0] step);
    uword_t w;
    unique case (step)
      5'd0:    w = '{CondTest,   SubYes, 5'd0,  ChrM, 10'd1000};
      5'd1:    w = '{CondTest,   SubNo,  5'd2,  ChrC, 10'd900};
      5'd2:    w = '{CondAlways, SubYes, 5'd1,  ChrM, 10'd900};
      5'd3:    w = '{CondTest,   SubYes, 5'd3,  ChrD, 10'd500};
      5'd4:    w = '{CondTest,   SubNo,  5'd5,  ChrC, 10'd400};
      5'd5:    w = '{CondAlways, SubYes, 5'd4,  ChrD, 10'd400};
      5'd6:    w = '{CondTest,   SubYes, 5'd6,  ChrC, 10'd100};
      5'd7:    w = '{CondTest,   SubNo,  5'd8,  ChrX, 10'd90};
      5'd8:    w = '{CondAlways, SubYes, 5'd7,  ChrC, 10'd90};
      5'd9:    w = '{CondTest,   SubYes, 5'd9,  ChrL, 10'd50};
      5'd10:   w = '{CondTest,   SubNo,  5'd11, ChrX, 10'd40};
      5'd11:   w = '{CondAlways, SubYes, 5'd10, ChrL, 10'd40};
      5'd12:   w = '{CondTest,   SubYes, 5'd12, ChrX, 10'd10};
      5'd13:   w = '{CondTest,   SubNo,  5'd14, ChrI, 10'd9};
      5'd14:   w = '{CondAlways, SubYes, 5'd13, ChrX, 10'd9};
      5'd15:   w = '{CondTest,   SubYes, 5'd15, ChrV, 10'd5};
      5'd16:   w = '{CondTest,   SubNo,  5'd17, ChrI, 10'd4};
      5'd17:   w = '{CondAlways, SubYes, 5'd16, ChrV, 10'd4};
      5'd18:   w = '{CondTest,   SubYes, 5'd18, ChrI, 10'd1};
      default: w = '{CondTest,   SubYes, 5'd18, ChrI, 10'd1};
    endcase
    return w;
  endfunction

endpackage

[sv/rne_dp.sv]
// Datapath of the Roman numeral encoder: remainder register, compare and result register.
module rne_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rne_pkg::NumW-1:0]  number,
  input  rne_pkg::ctrl_t            ctrl,
  output rne_pkg::stat_t            stat,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [rne_pkg::SymW-1:0]  symbol,
  output logic                      last,
  output logic                      range_error
);

  logic [rne_pkg::NumW-1:0] rest;
  logic [rne_pkg::NumW-1:0] weight_ext;

  assign weight_ext = {{(rne_pkg::NumW - rne_pkg::WeightW){1'b0}}, ctrl.weight};

  // Status for the sequencer.
  always_comb begin
    stat.in_range  = (number != '0) && (number <= rne_pkg::NumberMax);
    stat.ge        = (rest >= weight_ext);
    stat.eq        = (rest == weight_ext);
    stat.slot_free = !result_valid || !result_stall;
  end

  // Result valid flag: set by a new character or an error result, cleared once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.emit || ctrl.load_err) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Remainder: loaded on a new number, reduced after each completed symbol.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rest <= number;
    end else if (ctrl.emit && ctrl.sub) begin
      rest <= rest - weight_ext;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ctrl.load_err) begin
      symbol      <= '0;
      last        <= 1'b1;
      range_error <= 1'b1;
    end else if (ctrl.emit) begin
      symbol      <= ctrl.sym;
      last        <= ctrl.sub && stat.eq;
      range_error <= 1'b0;
    end
  end

`include "roman_numeral_encoder_unit_assert.svh"

  `RNE_ASSERT_NOW(a_err_is_last, result_valid && range_error, last && (symbol == '0), "error result must be a lone zero symbol")
  `RNE_ASSERT_NEXT(a_final_flagged, ctrl.emit && ctrl.sub && stat.eq, result_valid && last, "character that clears the remainder must be flagged last")

endmodule

[sv/rne_seq.sv]
// Microcode sequencer of the Roman numeral encoder: step counter, program ROM and jumps.
module rne_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           number_valid,
  output logic           number_stall,
  input  rne_pkg::stat_t stat,
  output rne_pkg::ctrl_t ctrl
);

  logic                      busy;
  logic                      busy_next;
  logic [rne_pkg::StepW-1:0] step;
  logic [rne_pkg::StepW-1:0] step_next;
  rne_pkg::uword_t           word;
  logic                      accept;
  logic                      take;

  assign word = rne_pkg::uword(step);

  // Input handshake: a new number only when idle and the result slot is free.
  assign number_stall = busy || !stat.slot_free;
  assign accept       = number_valid && !number_stall;

  // A step fires when the slot is free and its test passes or it is unconditional.
  assign take = busy && stat.slot_free && ((word.cond == rne_pkg::CondAlways) || stat.ge);

  // Controls to the datapath.
  always_comb begin
    ctrl.load     = accept;
    ctrl.load_err = accept && !stat.in_range;
    ctrl.emit     = take;
    ctrl.sub      = (word.sub == rne_pkg::SubYes);
    ctrl.sym      = word.sym;
    ctrl.weight   = word.weight;
  end

  // Next step: jump on a fired step, fall through on a failed test.
  always_comb begin
    busy_next = busy;
    step_next = step;
    if (accept) begin
      busy_next = stat.in_range;
      step_next = '0;
    end else if (busy && stat.slot_free) begin
      if (take) begin
        step_next = word.target;
        if ((word.sub == rne_pkg::SubYes) && stat.eq) begin
          busy_next = 1'b0;
        end
      end else if (word.sub == rne_pkg::SubNo) begin
        // A failed pair test skips the pair's second character.
        step_next = step + rne_pkg::StepW'(2);
      end else begin
        step_next = step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

`include "roman_numeral_encoder_unit_assert.svh"

  `RNE_ASSERT_NOW(a_step_in_prog, busy, step < rne_pkg::StepW'(rne_pkg::ProgLen), "step counter ran past the program")
  `RNE_ASSERT_NEXT(a_err_stays_idle, ctrl.load_err, !busy, "out-of-range number started a run")
  `RNE_ASSERT_NOW(a_emit_has_slot, ctrl.emit, stat.slot_free && !ctrl.load, "character emitted without a free result slot")

endmodule

[sv/roman_numeral_encoder_unit.sv]
// Top level of the Roman numeral encoder: converts a number to a run of numeral characters.
//
//   Channel   Handshake                    Payload
//   input     number_valid / number_stall  number[11:0]
//   output    result_valid / result_stall  symbol[6:0], last, range_error
//
// A number in 1 to 3999 is converted by the 19-step microcode program: each fired
// step emits one character and a failed test falls through; the sequencer stays
// busy until the last character and takes no new number meanwhile.
// An out-of-range number gives its single error result in the cycle after acceptance.
// Reset (rst, synchronous) empties the result register and idles the sequencer.
// A stalled output holds the sequencer in place; the next number is taken once
// the last character of a run sits in the result register.
module roman_numeral_encoder_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      number_valid,
  output logic                      number_stall,
  input  logic [rne_pkg::NumW-1:0]  number,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [rne_pkg::SymW-1:0]  symbol,
  output logic                      last,
  output logic                      range_error
);

  rne_pkg::ctrl_t ctrl;
  rne_pkg::stat_t stat;

  // Program sequencer.
  rne_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .number_valid (number_valid),
    .number_stall (number_stall),
    .stat         (stat),
    .ctrl         (ctrl)
  );

  // Remainder and result datapath.
  rne_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .number       (number),
    .ctrl         (ctrl),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .symbol       (symbol),
    .last         (last),
    .range_error  (range_error)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Roman numeral encoder testbench: directed and random numbers vs written or predicted runs.
module tb;

  // One output character as the checker sees it.
  typedef struct packed {
    logic [rne_pkg::SymW-1:0] sym;
    logic                     fin;
    logic                     err;
  } glyph_t;

  localparam int          DirRows    = 24;
  localparam int          RandCount  = 400;
  localparam int          TableLen   = 13;
  localparam int          DrainWait  = 40;
  localparam int          HoldStart  = 400;
  localparam int          HoldLen    = 100;
  localparam int          RecvCalmLo = 3000;
  localparam int          RecvCalmHi = 4000;
  localparam int          SendCalmLo = 150;
  localparam int          SendCalmHi = 250;
  localparam int          ReportMax  = 10;
  localparam logic [rne_pkg::SymW-1:0] NoChr = '0;

  // Row text: a numeral to expect, an empty string for a range error,
  // or an asterisk to leave the expectation to the predictor.
  localparam string UsePredictor = "*";

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     number_valid;
  logic                     number_stall;
  logic [rne_pkg::NumW-1:0] number;
  logic                     result_valid;
  logic                     result_stall;
  logic [rne_pkg::SymW-1:0] symbol;
  logic                     last;
  logic                     range_error;

  glyph_t expected_glyphs[$];
  int     fail_count    = 0;
  int     numbers_sent  = 0;
  int     bad_sent      = 0;
  int     glyphs_seen   = 0;
  bit     hold_done     = 1'b0;

  // Greedy conversion table, largest weight first.
  int unsigned     step_weight [TableLen] =
    '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
  logic [rne_pkg::SymW-1:0] lead_chr [TableLen] =
    '{rne_pkg::ChrM, rne_pkg::ChrC, rne_pkg::ChrD, rne_pkg::ChrC, rne_pkg::ChrC,
      rne_pkg::ChrX, rne_pkg::ChrL, rne_pkg::ChrX, rne_pkg::ChrX, rne_pkg::ChrI,
      rne_pkg::ChrV, rne_pkg::ChrI, rne_pkg::ChrI};
  logic [rne_pkg::SymW-1:0] tail_chr [TableLen] =
    '{NoChr, rne_pkg::ChrM, NoChr, rne_pkg::ChrD, NoChr, rne_pkg::ChrC, NoChr,
      rne_pkg::ChrL, NoChr, rne_pkg::ChrX, NoChr, rne_pkg::ChrV, NoChr};

  // Directed numbers: errors, extremes, every subtractive pair and the longest run.
  logic [rne_pkg::NumW-1:0] dir_number [DirRows] =
    '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd1000, 12'd2000,
      12'd3000, 12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50,
      12'd500, 12'd3, 12'd2048, 12'd1994, 12'd1444, 12'hAAA, 12'h555};
  string dir_numeral [DirRows] =
    '{"", "I", "MMMCMXCIX", "", "", "MMMDCCCLXXXVIII", "M", "MM",
      "MMM", "IV", "IX", "XL", "XC", "CD", "CM", "V", "L",
      "D", "III", "*", "*", "*", "*", "*"};

  roman_numeral_encoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .number_valid (number_valid),
    .number_stall (number_stall),
    .number       (number),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .symbol       (symbol),
    .last         (last),
    .range_error  (range_error)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Generous overall limit on the run.
  initial begin
    #4ms;
    $display("Timeout waiting for the encoder to finish");
    $display("Test completed with failures");
    $finish;
  end

  // Count a failure and describe the first few.
  function automatic void flag_failure(input string what);
    fail_count++;
    if (fail_count <= ReportMax) $display("%0t: %s", $realtime, what);
  endfunction

  // Predict the character run of one accepted number.
  function automatic void predict_numeral(input logic [rne_pkg::NumW-1:0] value);
    int unsigned rest;
    glyph_t      run[$];
    glyph_t      g;
    rest = value;
    if (rest < 1 || rest > rne_pkg::NumberMax) begin
      g = '{sym: NoChr, fin: 1'b1, err: 1'b1};
      expected_glyphs.push_back(g);
      return;
    end
    for (int t = 0; t < TableLen; t++) begin
      while (rest >= step_weight[t]) begin
        run.push_back('{sym: lead_chr[t], fin: 1'b0, err: 1'b0});
        if (tail_chr[t] != NoChr) run.push_back('{sym: tail_chr[t], fin: 1'b0, err: 1'b0});
        rest -= step_weight[t];
      end
    end
    run[run.size() - 1].fin = 1'b1;
    foreach (run[i]) expected_glyphs.push_back(run[i]);
  endfunction

  // Queue a run written out by hand; an empty string stands for a range error.
  function automatic void expect_numeral(input string txt);
    glyph_t g;
    if (txt.len() == 0) begin
      g = '{sym: NoChr, fin: 1'b1, err: 1'b1};
      expected_glyphs.push_back(g);
      return;
    end
    for (int i = 0; i < txt.len(); i++) begin
      g = '{sym: rne_pkg::SymW'(txt[i]), fin: (i == txt.len() - 1), err: 1'b0};
      expected_glyphs.push_back(g);
    end
  endfunction

  // Offer one number after an optional random idle gap and wait for the transaction.
  task automatic offer_number(input logic [rne_pkg::NumW-1:0] value, input string txt,
                              input bit calm);
    while (!calm && $urandom_range(0, 99) < 23) begin
      number_valid <= 1'b0;
      number       <= rne_pkg::NumW'($urandom);
      @(posedge clk);
    end
    number_valid <= 1'b1;
    number       <= value;
    do @(posedge clk); while (number_stall);
    numbers_sent++;
    if (value == 0 || value > rne_pkg::NumberMax) bad_sent++;
    if (txt == UsePredictor) predict_numeral(value);
    else expect_numeral(txt);
  endtask

  // Pick a random number: mostly valid values, some small, some long, some out of range.
  function automatic logic [rne_pkg::NumW-1:0] pick_number();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return rne_pkg::NumW'($urandom_range(4000, 4095));
    if (r < 25) return rne_pkg::NumW'($urandom_range(1, 39));
    if (r < 40) return rne_pkg::NumW'($urandom_range(3000, 3999));
    return rne_pkg::NumW'($urandom_range(1, 3999));
  endfunction

  // Stimulus and end of run.
  initial begin
    rst          <= 1'b1;
    number_valid <= 1'b0;
    number       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirRows; i++) begin
      offer_number(dir_number[i], dir_numeral[i], 1'b0);
    end
    for (int i = 0; i < RandCount; i++) begin
      offer_number(pick_number(), UsePredictor, (i >= SendCalmLo && i < SendCalmHi));
    end
    number_valid <= 1'b0;

    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (expected_glyphs.size() != 0) begin
      flag_failure($sformatf("%0d expected characters never arrived", expected_glyphs.size()));
    end

    $display("Converted %0d numbers (%0d out of range) into %0d checked characters,",
             numbers_sent, bad_sent, glyphs_seen);
    $display("with random idling on both sides and a %0d-cycle output hold-off (%s).",
             HoldLen, hold_done ? "done" : "missed");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off and a stretch with no stalls.
  initial begin
    int cycle;
    cycle = 0;
    result_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle >= HoldStart && cycle < HoldStart + HoldLen) begin
        result_stall <= 1'b1;
        hold_done = 1'b1;
      end else if (cycle >= RecvCalmLo && cycle < RecvCalmHi) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < 23);
      end
    end
  end

  // Compare each accepted character with the oldest expectation.
  always @(posedge clk) begin
    glyph_t want;
    if (!rst && result_valid && !result_stall) begin
      glyphs_seen++;
      if (expected_glyphs.size() == 0) begin
        flag_failure($sformatf("Unexpected character: symbol=%h last=%b range_error=%b",
                               symbol, last, range_error));
      end else begin
        want = expected_glyphs.pop_front();
        if (symbol !== want.sym || last !== want.fin || range_error !== want.err) begin
          flag_failure($sformatf(
            "Mismatch: expected symbol=%h last=%b range_error=%b, got %h %b %b",
            want.sym, want.fin, want.err, symbol, last, range_error));
        end
      end
    end
  end

endmodule
